// ===== hw/rtl/lir_pkg.sv =====
// Shared types and constants of the linear-interpolation resampler.
// Depends on nothing; the top level, lir_ctrl and lir_dp import it.
`default_nettype none

package lir_pkg;

	// Fixed field widths
	localparam int SAMPLE_BITS = 24;
	localparam int LEN_BITS    = 16;

	// Request mode codes
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	// Input request payload
	typedef struct packed {
		logic                          mode;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	// Result payload
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last;
	} result_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // append the request sample
		logic latch;      // capture index, clamps and path of a new request
		logic mul1;       // position product i*(n-1)
		logic div1_go;    // start position division
		logic div1_take;  // capture whole part and remainder
		logic rd_second;  // read address selects the upper neighbor
		logic cap_s0;     // capture first sample read
		logic cap_s1;     // capture difference of neighbors
		logic mul2;       // slope product (s1-s0)*r
		logic div2_go;    // start slope division
		logic emit;       // register the result and update counters
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic n_zero;      // store is empty
		logic replay;      // counters call for replay of stored samples
		logic run_replay;  // request in flight is a replay
		logic div_done;    // divider finished
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/linear_interp_resampler.sv =====
// Top level of the linear-interpolation resampler: controller plus datapath.
// Depends on lir_pkg, lir_ctrl, lir_dp (and through it lir_ram, lir_div).
//
//   channel   signals                          direction  handshake
//   request   start, busy, item                in         start & !busy
//   result    result_valid, result             out        one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_data   in         valid & ready
//
// A load request leaves busy low, so loads stream back to back.
// An interpolating request holds busy while the one-bit-per-cycle divider runs
// for the position and then for the slope. A replay request holds busy through
// S_RD0, S_RD1 and S_FIN; a request on an empty store is taken without raising
// busy and yields nothing.
// Reset clears counters, out_length and control; the sample store is not cleared.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none

module linear_interp_resampler #(
	parameter int MAX_INPUT_SAMPLES = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire lir_pkg::item_t                item,
	output logic                               result_valid,
	output lir_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lir_pkg::LEN_BITS-1:0]  cfg_data
);

	import lir_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    cfg_we;

	// Take config writes only while idle
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	lir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	lir_dp #(
		.MAX_INPUT_SAMPLES (MAX_INPUT_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.sample       (item.sample),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid)
	);

	// Results are spaced apart by the sequencer
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for two cycles");

	// A result follows a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a preceding busy period");

	// A load never blocks the next request
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.mode == MODE_LOAD)) |=> !busy)
		else $error("load request raised busy");

endmodule

`default_nettype wire

// ===== hw/rtl/lir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module lir_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lir_div.sv =====
// Restoring divider, one quotient bit per cycle, numerator given left-aligned.
// Depends on nothing; shared by both divisions of the datapath.
`default_nettype none

module lir_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 16,
	localparam int CW = $clog2(NUM_W + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [CW-1:0]    len,
	output logic      [NUM_W-1:0] quo,
	output logic      [DEN_W-1:0] rem,
	output logic                  done
);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_sub;
	logic           fits;

	// Shift in the next numerator bit and try the subtraction
	always_comb begin
		trial     = {rem_q, num_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den};
		fits      = (trial >= {1'b0, den});
	end

	// Control: run for len steps, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= len;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: partial remainder, quotient and numerator shift
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			quo_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lir_ctrl.sv =====
// Controller state machine of the resampler: accepts requests and sequences
// the datapath. Depends on lir_pkg.
`default_nettype none

module lir_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              mode,
	input  wire lir_pkg::status_t  st,
	output lir_pkg::cmd_t          cmd,
	output logic                   busy
);

	import lir_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_MUL1  = 11'b000_0000_0010,
		S_DIV1  = 11'b000_0000_0100,
		S_WAIT1 = 11'b000_0000_1000,
		S_RD0   = 11'b000_0001_0000,
		S_RD1   = 11'b000_0010_0000,
		S_RD2   = 11'b000_0100_0000,
		S_MUL2  = 11'b000_1000_0000,
		S_DIV2  = 11'b001_0000_0000,
		S_WAIT2 = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_LOAD) begin
						cmd.load = 1'b1;
					end else if (!st.n_zero) begin
						cmd.latch = 1'b1;
						state_d   = st.replay ? S_RD0 : S_MUL1;
					end
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_DIV1;
			end
			S_DIV1: begin
				cmd.div1_go = 1'b1;
				state_d     = S_WAIT1;
			end
			S_WAIT1: begin
				if (st.div_done) begin
					cmd.div1_take = 1'b1;
					state_d       = S_RD0;
				end
			end
			S_RD0: begin
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.rd_second = 1'b1;
				cmd.cap_s0    = 1'b1;
				state_d       = st.run_replay ? S_FIN : S_RD2;
			end
			S_RD2: begin
				cmd.cap_s1 = 1'b1;
				state_d    = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2_go = 1'b1;
				state_d     = S_WAIT2;
			end
			S_WAIT2: begin
				if (st.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/lir_dp.sv =====
// Datapath of the resampler: counters, sample store, multipliers, shared
// serial divider and result register. Depends on lir_pkg, lir_ram, lir_div.
`default_nettype none

module lir_dp #(
	parameter int MAX_INPUT_SAMPLES = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire lir_pkg::cmd_t                        cmd,
	output lir_pkg::status_t                          st,
	input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic                                 cfg_we,
	input  wire logic [lir_pkg::LEN_BITS-1:0]         cfg_data,
	output lir_pkg::result_t                          result,
	output logic                                      result_valid
);

	import lir_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int DEN_W  = LEN_BITS;
	localparam int CNT_W  = $clog2(MAX_INPUT_SAMPLES + 1);
	localparam int AW     = (MAX_INPUT_SAMPLES > 1) ? $clog2(MAX_INPUT_SAMPLES) : 1;
	localparam int P1_W   = DEN_W + CNT_W;
	localparam int MAG_W  = SB + DEN_W;
	localparam int NUM_W  = (P1_W > MAG_W) ? P1_W : MAG_W;
	localparam int LEN_CW = $clog2(NUM_W + 1);
	localparam int P2_W   = SB + DEN_W + 2;

	// Architectural state
	logic [DEN_W-1:0] out_length_q;
	logic [CNT_W-1:0] loaded_count_q;
	logic [DEN_W-1:0] output_index_q;

	// Per-request working registers
	logic                    replay_q;
	logic                    last_q;
	logic [DEN_W-1:0]        i_eff_q;
	logic [CNT_W-1:0]        nm1_q;
	logic [DEN_W-1:0]        den_q;
	logic [P1_W-1:0]         prod1_q;
	logic [AW-1:0]           q_q;
	logic [AW-1:0]           q1_q;
	logic [DEN_W-1:0]        r_q;
	logic [SB-1:0]           s0_q;
	logic signed [SB:0]      diff_q;
	logic signed [P2_W-1:0]  prod2_q;
	result_t                 result_q;
	logic                    result_valid_q;

	// Store and divider wiring
	logic          ram_we;
	logic [AW-1:0] raddr;
	logic [SB-1:0] rdata;
	logic              div_go;
	logic [NUM_W-1:0]  div_num;
	logic [LEN_CW-1:0] div_len;
	logic [NUM_W-1:0]  div_quo;
	logic [DEN_W-1:0]  div_rem;
	logic              div_done;

	// Request decode helpers
	logic [CNT_W-1:0] nm1;
	logic [DEN_W-1:0] mm1;
	logic             rep_last;
	logic             int_last;
	logic             replay;
	logic [DEN_W-1:0] i_eff;
	logic [AW-1:0]    q_w;

	// Division operands and result assembly
	logic [P2_W-1:0]  mag;
	logic [SB+1:0]    q_ext;
	logic [SB+1:0]    q_up;
	logic [SB+1:0]    floor_v;
	logic [SB+1:0]    sum;
	logic [SB-1:0]    value;

	// Clamp the output index and pick the path of a new request
	always_comb begin
		nm1      = loaded_count_q - 1'b1;
		mm1      = out_length_q - 1'b1;
		replay   = (loaded_count_q < CNT_W'(2)) || (out_length_q < DEN_W'(2));
		rep_last = (32'(output_index_q) >= 32'(nm1));
		int_last = (output_index_q >= mm1);
		if (replay) begin
			i_eff = rep_last ? DEN_W'(nm1) : output_index_q;
		end else begin
			i_eff = int_last ? mm1 : output_index_q;
		end
	end

	assign st.n_zero     = (loaded_count_q == '0);
	assign st.replay     = replay;
	assign st.run_replay = replay_q;
	assign st.div_done   = div_done;

	// Config register and run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_length_q   <= '0;
			loaded_count_q <= '0;
			output_index_q <= '0;
		end else begin
			if (cfg_we) begin
				out_length_q <= cfg_data;
			end
			if (ram_we) begin
				loaded_count_q <= loaded_count_q + 1'b1;
			end
			if (cmd.emit) begin
				if (last_q) begin
					loaded_count_q <= '0;
					output_index_q <= '0;
				end else begin
					output_index_q <= i_eff_q + 1'b1;
				end
			end
		end
	end

	// Sample store: append while not full
	assign ram_we = cmd.load && (loaded_count_q < CNT_W'(MAX_INPUT_SAMPLES));
	assign raddr  = cmd.rd_second ? q1_q : (replay_q ? i_eff_q[AW-1:0] : q_q);

	lir_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_INPUT_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (loaded_count_q[AW-1:0]),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared divider: position first, then slope
	always_comb begin
		mag     = prod2_q[P2_W-1] ? (~prod2_q + 1'b1) : prod2_q;
		div_go  = cmd.div1_go || cmd.div2_go;
		if (cmd.div2_go) begin
			div_num = NUM_W'(mag[MAG_W-1:0]) << (NUM_W - MAG_W);
			div_len = LEN_CW'(MAG_W);
		end else begin
			div_num = NUM_W'(prod1_q) << (NUM_W - P1_W);
			div_len = LEN_CW'(P1_W);
		end
	end

	lir_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (den_q),
		.len    (div_len),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	assign q_w = div_quo[AW-1:0];

	// Working registers of one request
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			replay_q <= replay;
			last_q   <= replay ? rep_last : int_last;
			i_eff_q  <= i_eff;
			nm1_q    <= nm1;
			den_q    <= mm1;
		end
		if (cmd.mul1) begin
			prod1_q <= P1_W'(i_eff_q) * P1_W'(nm1_q);
		end
		if (cmd.div1_take) begin
			q_q  <= q_w;
			q1_q <= (CNT_W'(q_w) < nm1_q) ? AW'(q_w + 1'b1) : q_w;
			r_q  <= div_rem;
		end
		if (cmd.cap_s0) begin
			s0_q <= rdata;
		end
		if (cmd.cap_s1) begin
			diff_q <= $signed({rdata[SB-1], rdata}) - $signed({s0_q[SB-1], s0_q});
		end
		if (cmd.mul2) begin
			prod2_q <= diff_q * $signed({1'b0, r_q});
		end
	end

	// Floor of the signed slope division, added to the lower neighbor
	always_comb begin
		q_ext   = {1'b0, div_quo[SB:0]};
		q_up    = q_ext + {{(SB+1){1'b0}}, (div_rem != '0)};
		floor_v = prod2_q[P2_W-1] ? (~q_up + 1'b1) : q_ext;
		sum     = {{2{s0_q[SB-1]}}, s0_q} + floor_v;
		value   = replay_q ? s0_q : sum[SB-1:0];
	end

	// Result register and strobe
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.value <= value;
			result_q.last  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire
